@@ rtl/fpa_pkg.sv @@
// Shared opcodes, widths and the side-band record carried through the ALU pipeline.
package fpa_pkg;

    localparam int DATA_W = 32;
    localparam int OP_W   = 4;

    localparam logic [OP_W-1:0] OP_ADD      = 4'd0;
    localparam logic [OP_W-1:0] OP_SUB      = 4'd1;
    localparam logic [OP_W-1:0] OP_MUL      = 4'd2;
    localparam logic [OP_W-1:0] OP_DIV      = 4'd3;
    localparam logic [OP_W-1:0] OP_MIN      = 4'd4;
    localparam logic [OP_W-1:0] OP_MAX      = 4'd5;
    localparam logic [OP_W-1:0] OP_INC      = 4'd6;
    localparam logic [OP_W-1:0] OP_DEC      = 4'd7;
    localparam logic [OP_W-1:0] OP_FROM_INT = 4'd8;
    localparam logic [OP_W-1:0] OP_TO_INT   = 4'd9;

    typedef struct packed {
        logic [DATA_W-1:0] res;
        logic              less;
        logic              eq;
        logic              dz;
        logic              is_div;
        logic              is_mul;
        logic              neg;
    } t_side;

endpackage

@@ rtl/fixed_point_alu.sv @@
// Top level of the signed 32-bit fixed-point ALU.
// The divider spends one stage on each of the 32 + FRAC_BITS quotient bits.
// Throughput: one beat per cycle; a stall at the output freezes the whole pipeline.
// Reset is synchronous and active low and clears only the valid bits of the stages.
module fixed_point_alu
    import fpa_pkg::*;
#(
    parameter int FRAC_BITS = 8
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_valid,
    output logic                     o_stall,
    input  logic [OP_W-1:0]          i_req_type,
    input  logic signed [DATA_W-1:0] i_operand_a,
    input  logic signed [DATA_W-1:0] i_operand_b,
    output logic                     o_valid,
    input  logic                     i_stall,
    output logic signed [DATA_W-1:0] o_result,
    output logic                     o_a_less_b,
    output logic                     o_a_equal_b,
    output logic                     o_divide_by_zero
);

    localparam int NUM_W  = DATA_W + FRAC_BITS;
    localparam int PROD_W = 2 * DATA_W;

    logic w_adv;

    // Stage 0: input register.
    logic              r_s0_vld;
    logic [OP_W-1:0]   r_s0_op;
    logic [DATA_W-1:0] r_s0_a;
    logic [DATA_W-1:0] r_s0_b;

    // Stage 1: magnitudes, flags and the simple results.
    logic              r_s1_vld;
    logic [DATA_W-1:0] r_s1_mag_a;
    logic [DATA_W-1:0] r_s1_mag_b;
    t_side             r_s1_side;

    // Stage 2: product.
    logic              r_s2_vld;
    logic [PROD_W-1:0] r_s2_prod;
    logic [DATA_W-1:0] r_s2_mag_a;
    logic [DATA_W-1:0] r_s2_mag_b;
    t_side             r_s2_side;

    // Stage 3: rounded product, divider operands.
    logic              r_s3_vld;
    logic [NUM_W-1:0]  r_s3_num;
    logic [DATA_W-1:0] r_s3_den;
    t_side             r_s3_side;

    // Output register.
    logic              r_out_vld;
    logic [DATA_W-1:0] r_out_res;
    logic              r_out_less;
    logic              r_out_eq;
    logic              r_out_dz;

    assign w_adv   = !r_out_vld || !i_stall;
    assign o_stall = !w_adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s0_vld <= 1'b0;
        end else if (w_adv) begin
            r_s0_vld <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_s0_op <= i_req_type;
            r_s0_a  <= i_operand_a;
            r_s0_b  <= i_operand_b;
        end
    end

    logic              w_a_neg;
    logic              w_b_neg;
    logic [DATA_W-1:0] w_mag_a;
    logic [DATA_W-1:0] w_mag_b;
    logic [DATA_W-1:0] w_trunc;
    logic              w_less;
    t_side             n_s1_side;

    assign w_a_neg = r_s0_a[DATA_W-1];
    assign w_b_neg = r_s0_b[DATA_W-1];
    assign w_mag_a = w_a_neg ? (~r_s0_a + 1'b1) : r_s0_a;
    assign w_mag_b = w_b_neg ? (~r_s0_b + 1'b1) : r_s0_b;
    assign w_trunc = w_mag_a >> FRAC_BITS;
    assign w_less  = $signed(r_s0_a) < $signed(r_s0_b);

    always_comb begin
        n_s1_side        = '0;
        n_s1_side.less   = w_less;
        n_s1_side.eq     = r_s0_a == r_s0_b;
        n_s1_side.neg    = w_a_neg ^ w_b_neg;
        case (r_s0_op)
            OP_ADD:      n_s1_side.res = r_s0_a + r_s0_b;
            OP_SUB:      n_s1_side.res = r_s0_a - r_s0_b;
            OP_MUL:      n_s1_side.is_mul = 1'b1;
            OP_DIV: begin
                n_s1_side.is_div = 1'b1;
                n_s1_side.dz     = r_s0_b == '0;
            end
            OP_MIN:      n_s1_side.res = w_less ? r_s0_a : r_s0_b;
            OP_MAX:      n_s1_side.res = w_less ? r_s0_b : r_s0_a;
            OP_INC:      n_s1_side.res = r_s0_a + 1'b1;
            OP_DEC:      n_s1_side.res = r_s0_a - 1'b1;
            OP_FROM_INT: n_s1_side.res = r_s0_a << FRAC_BITS;
            OP_TO_INT:   n_s1_side.res = w_a_neg ? (~w_trunc + 1'b1) : w_trunc;
            default:     n_s1_side.res = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
            r_s2_vld <= 1'b0;
            r_s3_vld <= 1'b0;
        end else if (w_adv) begin
            r_s1_vld <= r_s0_vld;
            r_s2_vld <= r_s1_vld;
            r_s3_vld <= r_s2_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_s1_mag_a <= w_mag_a;
            r_s1_mag_b <= w_mag_b;
            r_s1_side  <= n_s1_side;
            r_s2_prod  <= r_s1_mag_a * r_s1_mag_b;
            r_s2_mag_a <= r_s1_mag_a;
            r_s2_mag_b <= r_s1_mag_b;
            r_s2_side  <= r_s1_side;
        end
    end

    localparam logic [PROD_W-1:0] HALF = PROD_W'(1) << (FRAC_BITS - 1);

    logic [PROD_W-1:0] w_round;
    logic [PROD_W-1:0] w_prod_q;
    logic [DATA_W-1:0] w_mul_mag;
    t_side             n_s3_side;

    assign w_round   = r_s2_prod + HALF;
    assign w_prod_q  = w_round >> FRAC_BITS;
    assign w_mul_mag = w_prod_q[DATA_W-1:0];

    always_comb begin
        n_s3_side = r_s2_side;
        if (r_s2_side.is_mul) begin
            n_s3_side.res = r_s2_side.neg ? (~w_mul_mag + 1'b1) : w_mul_mag;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_s3_num  <= {r_s2_mag_a, {FRAC_BITS{1'b0}}};
            r_s3_den  <= r_s2_mag_b;
            r_s3_side <= n_s3_side;
        end
    end

    logic              w_div_vld;
    logic [DATA_W-1:0] w_quot;
    logic [DATA_W-1:0] w_rem;
    logic [DATA_W-1:0] w_den;
    t_side             w_div_side;

    fpa_div #(
        .NUM_W (NUM_W)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (w_adv),
        .i_valid (r_s3_vld),
        .i_num   (r_s3_num),
        .i_den   (r_s3_den),
        .i_side  (r_s3_side),
        .o_valid (w_div_vld),
        .o_quot  (w_quot),
        .o_rem   (w_rem),
        .o_den   (w_den),
        .o_side  (w_div_side)
    );

    // Round half away from zero on the magnitude, then restore the sign.
    logic              w_up;
    logic [DATA_W-1:0] w_qr;
    logic [DATA_W-1:0] n_out_res;

    assign w_up = {w_rem, 1'b0} >= {1'b0, w_den};
    assign w_qr = w_quot + {{(DATA_W-1){1'b0}}, w_up};

    always_comb begin
        n_out_res = w_div_side.res;
        if (w_div_side.is_div) begin
            if (w_div_side.dz) begin
                n_out_res = '0;
            end else begin
                n_out_res = w_div_side.neg ? (~w_qr + 1'b1) : w_qr;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (w_adv) begin
            r_out_vld <= w_div_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_out_res  <= n_out_res;
            r_out_less <= w_div_side.less;
            r_out_eq   <= w_div_side.eq;
            r_out_dz   <= w_div_side.dz;
        end
    end

    assign o_valid          = r_out_vld;
    assign o_result         = r_out_res;
    assign o_a_less_b       = r_out_less;
    assign o_a_equal_b      = r_out_eq;
    assign o_divide_by_zero = r_out_dz;

`ifndef SYNTHESIS
    a_dz_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_divide_by_zero |-> o_result == '0)
        else $error("divide by zero beat with nonzero result");

    a_eq_not_less: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_a_equal_b |-> !o_a_less_b)
        else $error("equal and less flags both set");

    a_stall_needs_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> o_valid)
        else $error("pipeline stalled without a pending result");
`endif

endmodule

@@ rtl/fpa_div.sv @@
// Restoring divider pipeline, one quotient bit per stage, carrying side-band data.
module fpa_div
    import fpa_pkg::*;
#(
    parameter int NUM_W = 40
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_adv,
    input  logic              i_valid,
    input  logic [NUM_W-1:0]  i_num,
    input  logic [DATA_W-1:0] i_den,
    input  t_side             i_side,
    output logic              o_valid,
    output logic [DATA_W-1:0] o_quot,
    output logic [DATA_W-1:0] o_rem,
    output logic [DATA_W-1:0] o_den,
    output t_side             o_side
);

    logic              r_vld  [NUM_W];
    logic [DATA_W-1:0] r_rem  [NUM_W];
    logic [NUM_W-1:0]  r_num  [NUM_W];
    logic [DATA_W-1:0] r_quot [NUM_W];
    logic [DATA_W-1:0] r_den  [NUM_W];
    t_side             r_side [NUM_W];

    for (genvar k = 0; k < NUM_W; k++) begin : g_stage
        logic              w_vld;
        logic [DATA_W-1:0] w_rem;
        logic [NUM_W-1:0]  w_num;
        logic [DATA_W-1:0] w_quot;
        logic [DATA_W-1:0] w_den;
        t_side             w_side;
        logic [DATA_W:0]   w_trial;
        logic              w_ge;
        logic [DATA_W:0]   w_diff;
        logic [DATA_W-1:0] n_rem;

        if (k == 0) begin : g_first
            assign w_vld  = i_valid;
            assign w_rem  = '0;
            assign w_num  = i_num;
            assign w_quot = '0;
            assign w_den  = i_den;
            assign w_side = i_side;
        end else begin : g_next
            assign w_vld  = r_vld[k-1];
            assign w_rem  = r_rem[k-1];
            assign w_num  = r_num[k-1];
            assign w_quot = r_quot[k-1];
            assign w_den  = r_den[k-1];
            assign w_side = r_side[k-1];
        end

        // The partial remainder stays below the divisor, so 32 bits hold it.
        assign w_trial = {w_rem, w_num[NUM_W-1]};
        assign w_ge    = w_trial >= {1'b0, w_den};
        assign w_diff  = w_trial - {1'b0, w_den};
        assign n_rem   = w_ge ? w_diff[DATA_W-1:0] : w_trial[DATA_W-1:0];

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[k] <= 1'b0;
            end else if (i_adv) begin
                r_vld[k] <= w_vld;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_adv) begin
                r_rem[k]  <= n_rem;
                r_num[k]  <= {w_num[NUM_W-2:0], 1'b0};
                r_quot[k] <= {w_quot[DATA_W-2:0], w_ge};
                r_den[k]  <= w_den;
                r_side[k] <= w_side;
            end
        end
    end

    assign o_valid = r_vld[NUM_W-1];
    assign o_quot  = r_quot[NUM_W-1];
    assign o_rem   = r_rem[NUM_W-1];
    assign o_den   = r_den[NUM_W-1];
    assign o_side  = r_side[NUM_W-1];

endmodule
